// File: hw/rtl/m4fm_pkg.sv
// types, constants and binary32 arithmetic helpers for the 4x4 float matrix product
// no dependencies; used by matrix4_float_multiply
`default_nettype none

package m4fm_pkg;

  localparam int STORE_SIDE     = 4;
  localparam int MATRIX_DIM_DEF = 4;
  localparam int FP_W           = 32;

  // request operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MUL  = 1'b1;

  // default quiet nan produced by invalid operations
  localparam logic [FP_W-1:0] FP_QNAN  = 32'hFFC0_0000;
  localparam logic [FP_W-1:0] FP_QBIT  = 32'h0040_0000;

  // operand ready for normalise and round: value = mag * 2^(be_base - 127 - 51)
  typedef struct packed {
    logic              spec;
    logic [FP_W-1:0]   spec_val;
    logic              sign;
    logic signed [11:0] be_base;
    logic [51:0]       mag;
  } rnd_in_t;

  // first half of a multiply: specials and the raw mantissa product
  function automatic rnd_in_t fp_mul_pre(input logic [FP_W-1:0] a, input logic [FP_W-1:0] b);
    rnd_in_t    r;
    logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0] ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    a_nan  = (&a[30:23]) && (|a[22:0]);
    b_nan  = (&b[30:23]) && (|b[22:0]);
    a_inf  = (&a[30:23]) && !(|a[22:0]);
    b_inf  = (&b[30:23]) && !(|b[22:0]);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    p  = ma * mb;
    r.sign     = a[31] ^ b[31];
    r.mag      = {4'd0, p};
    r.be_base  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd122;
    r.spec     = 1'b1;
    r.spec_val = FP_QNAN;
    if (a_nan) begin
      r.spec_val = a | FP_QBIT;
    end else if (b_nan) begin
      r.spec_val = b | FP_QBIT;
    end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
      r.spec_val = FP_QNAN;
    end else if (a_inf || b_inf) begin
      r.spec_val = {r.sign, 8'hFF, 23'd0};
    end else begin
      r.spec = 1'b0;
    end
    return r;
  endfunction

  // first half of an add: specials, magnitude swap, alignment and the wide add
  function automatic rnd_in_t fp_add_pre(input logic [FP_W-1:0] a, input logic [FP_W-1:0] b);
    rnd_in_t    r;
    logic       a_nan, b_nan, a_inf, b_inf;
    logic [FP_W-1:0] x, y;
    logic [7:0] ex, ey, d;
    logic [51:0] xw, yw, ys;
    logic       st;
    a_nan = (&a[30:23]) && (|a[22:0]);
    b_nan = (&b[30:23]) && (|b[22:0]);
    a_inf = (&a[30:23]) && !(|a[22:0]);
    b_inf = (&b[30:23]) && !(|b[22:0]);
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d  = ex - ey;
    xw = {1'b0, |x[30:23], x[22:0], 27'd0};
    yw = {1'b0, |y[30:23], y[22:0], 27'd0};
    if (d >= 8'd52) begin
      ys = 52'd0;
      st = |yw;
    end else begin
      ys = yw >> d[5:0];
      st = |(yw & ((52'd1 << d[5:0]) - 52'd1));
    end
    ys[0] = ys[0] | st;
    if (x[31] == y[31]) begin
      r.mag = xw + ys;
    end else begin
      r.mag = xw - ys;
    end
    // exact cancellation rounds to +0, equal-signed zeros keep their sign
    r.sign    = (r.mag == 52'd0) ? (a[31] & b[31]) : x[31];
    r.be_base = $signed({4'd0, ex}) + 12'sd1;
    r.spec     = 1'b1;
    r.spec_val = FP_QNAN;
    if (a_nan) begin
      r.spec_val = a | FP_QBIT;
    end else if (b_nan) begin
      r.spec_val = b | FP_QBIT;
    end else if (a_inf && b_inf && (a[31] != b[31])) begin
      r.spec_val = FP_QNAN;
    end else if (a_inf) begin
      r.spec_val = a;
    end else if (b_inf) begin
      r.spec_val = b;
    end else begin
      r.spec = 1'b0;
    end
    return r;
  endfunction

  // second half: normalise, denormalise when tiny, round to nearest even, pack
  function automatic logic [FP_W-1:0] fp_round(input rnd_in_t r);
    logic [51:0] mn, sh;
    logic [5:0]  lz;
    logic signed [11:0] be, s;
    logic [7:0]  ef;
    logic        dst, g, st, up;
    logic [30:0] res;
    mn  = r.mag;
    lz  = 6'd0;
    dst = 1'b0;
    // six-step leading zero count and shift
    if (mn[51:20] == 32'd0) begin mn = mn << 32; lz = lz + 6'd32; end
    if (mn[51:36] == 16'd0) begin mn = mn << 16; lz = lz + 6'd16; end
    if (mn[51:44] == 8'd0)  begin mn = mn << 8;  lz = lz + 6'd8;  end
    if (mn[51:48] == 4'd0)  begin mn = mn << 4;  lz = lz + 6'd4;  end
    if (mn[51:50] == 2'd0)  begin mn = mn << 2;  lz = lz + 6'd2;  end
    if (mn[51] == 1'b0)     begin mn = mn << 1;  lz = lz + 6'd1;  end
    be = r.be_base - $signed({6'd0, lz});
    s  = 12'sd1 - be;
    if (be >= 12'sd1) begin
      sh = mn;
      ef = be[7:0];
    end else if (s >= 12'sd52) begin
      sh  = 52'd0;
      dst = |mn;
      ef  = 8'd0;
    end else begin
      sh  = mn >> s[5:0];
      dst = |(mn & ((52'd1 << s[5:0]) - 52'd1));
      ef  = 8'd0;
    end
    g   = sh[27];
    st  = (|sh[26:0]) | dst;
    up  = g & (st | sh[28]);
    res = {ef, sh[50:28]} + {30'd0, up};
    if (r.spec) begin
      return r.spec_val;
    end else if (r.mag == 52'd0) begin
      return {r.sign, 31'd0};
    end else if (be >= 12'sd255) begin
      return {r.sign, 8'hFF, 23'd0};
    end else begin
      return {r.sign, res};
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/matrix4_float_multiply.sv
// throughput: one request per cycle unless the output register is stalled;
// a multiply row enters while earlier rows are in flight
// the pipeline is one multiply pair of stages then an add pair of stages per further term
// the whole pipeline holds only while its output register is stalled
// reset: synchronous, clears the stage valid bits; the right matrix is undefined until loaded
// depends on m4fm_pkg
`default_nettype none

module matrix4_float_multiply #(
  parameter int MATRIX_DIM = m4fm_pkg::MATRIX_DIM_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [1:0]  in_row_index,
  input  wire logic [31:0] in_elem_0,
  input  wire logic [31:0] in_elem_1,
  input  wire logic [31:0] in_elem_2,
  input  wire logic [31:0] in_elem_3,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_row,
  output logic [31:0]      out_prod_0,
  output logic [31:0]      out_prod_1,
  output logic [31:0]      out_prod_2,
  output logic [31:0]      out_prod_3
);
  import m4fm_pkg::*;

  localparam int NST   = 2 * MATRIX_DIM;
  localparam int IDX_W = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;

  logic [FP_W-1:0] elem [STORE_SIDE];
  logic [FP_W-1:0] right_r [MATRIX_DIM][MATRIX_DIM];
  logic            v_r   [NST];
  logic [1:0]      row_r [NST];
  rnd_in_t         mp_r  [MATRIX_DIM][MATRIX_DIM];
  logic [FP_W-1:0] pr_r  [NST-1][MATRIX_DIM][MATRIX_DIM];
  rnd_in_t         ap_r  [MATRIX_DIM-1][MATRIX_DIM];
  logic [FP_W-1:0] acc_r [MATRIX_DIM-1][MATRIX_DIM];
  logic [FP_W-1:0] res   [STORE_SIDE];
  logic            adv;
  logic            row_ok;

  assign elem[0] = in_elem_0;
  assign elem[1] = in_elem_1;
  assign elem[2] = in_elem_2;
  assign elem[3] = in_elem_3;

  // global advance: the pipeline moves unless the output register is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign row_ok   = (32'(in_row_index) < MATRIX_DIM);

  // right matrix store, written by load requests
  always_ff @(posedge clk) begin
    if (in_valid && adv && (in_operation == OP_LOAD) && row_ok) begin
      for (int c = 0; c < MATRIX_DIM; c++) begin
        right_r[in_row_index[IDX_W-1:0]][c] <= elem[c];
      end
    end
  end

  // valid bits and row labels travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int h = 0; h < NST; h++) begin
        v_r[h] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= in_valid && (in_operation == OP_MUL);
      for (int h = 1; h < NST; h++) begin
        v_r[h] <= v_r[h-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      row_r[0] <= in_row_index;
      for (int h = 1; h < NST; h++) begin
        row_r[h] <= row_r[h-1];
      end
    end
  end

  // stage 0: mantissa products of all terms
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < MATRIX_DIM; k++) begin
        for (int c = 0; c < MATRIX_DIM; c++) begin
          mp_r[k][c] <= fp_mul_pre(elem[k], right_r[k][c]);
        end
      end
    end
  end

  // stage 1: rounded products, then carried down the pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < MATRIX_DIM; k++) begin
        for (int c = 0; c < MATRIX_DIM; c++) begin
          pr_r[0][k][c] <= fp_round(mp_r[k][c]);
          for (int p = 1; p < NST - 1; p++) begin
            pr_r[p][k][c] <= pr_r[p-1][k][c];
          end
        end
      end
    end
  end

  // one align/add stage and one round stage for each further term, in k order
  for (genvar j = 1; j < MATRIX_DIM; j++) begin : g_add
    logic [FP_W-1:0] acc_in [MATRIX_DIM];
    for (genvar c = 0; c < MATRIX_DIM; c++) begin : g_col
      if (j == 1) begin : g_first
        assign acc_in[c] = pr_r[0][0][c];
      end else begin : g_next
        assign acc_in[c] = acc_r[j-2][c];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int c = 0; c < MATRIX_DIM; c++) begin
          ap_r[j-1][c]  <= fp_add_pre(acc_in[c], pr_r[2*j-2][j][c]);
          acc_r[j-1][c] <= fp_round(ap_r[j-1][c]);
        end
      end
    end
  end

  // result row; columns beyond the dimension read as zero
  for (genvar c = 0; c < STORE_SIDE; c++) begin : g_res
    if (c < MATRIX_DIM) begin : g_used
      assign res[c] = acc_r[MATRIX_DIM-2][c];
    end else begin : g_unused
      assign res[c] = '0;
    end
  end

  assign out_valid  = v_r[NST-1];
  assign out_row    = row_r[NST-1];
  assign out_prod_0 = res[0];
  assign out_prod_1 = res[1];
  assign out_prod_2 = res[2];
  assign out_prod_3 = res[3];

  // a load request never enters the arithmetic pipeline
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_operation == OP_LOAD)) |=> !v_r[0])
    else $error("load request entered the pipeline");

  // input is held back only by a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output stall");

  // with the output free the first stage moves on
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !out_stall) |=> (v_r[1] == $past(v_r[0])))
    else $error("pipeline stage did not advance");

endmodule

`default_nettype wire

// File: bench/tb_matrix4_float_multiply.sv
// self-checking bench for matrix4_float_multiply: row loads and row multiplies,
// predicted with an exact integer model of binary32 multiply and add
// depends on m4fm_pkg and the matrix4_float_multiply rtl
`default_nettype none

module tb_matrix4_float_multiply;
  import m4fm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct {
    logic             op;
    logic [1:0]       row;
    logic [3:0][31:0] el;
    bit               drain;
  } row_req_t;

  typedef struct {
    logic [1:0]       row;
    logic [3:0][31:0] prod;
  } prod_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_operation = OP_LOAD;
  logic [1:0] in_row_index = 2'd0;
  logic [31:0] in_elem_0 = 32'd0, in_elem_1 = 32'd0, in_elem_2 = 32'd0, in_elem_3 = 32'd0;
  logic out_stall = 1'b0;
  wire logic in_stall, out_valid;
  wire logic [1:0] out_row;
  wire logic [31:0] out_prod_0, out_prod_1, out_prod_2, out_prod_3;

  row_req_t  pending[$];
  prod_row_t awaited[$];
  logic [31:0] right_rows[4][4];
  row_req_t cur;
  int gap = 0, burst_left = 0;
  int n_loads = 0, n_mults = 0, n_checked = 0, n_errors = 0, n_cycles = 0;
  int stall_mode = 0, stall_run = 0;

  matrix4_float_multiply DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_row_index(in_row_index),
    .in_elem_0(in_elem_0), .in_elem_1(in_elem_1),
    .in_elem_2(in_elem_2), .in_elem_3(in_elem_3),
    .out_valid(out_valid), .out_stall(out_stall), .out_row(out_row),
    .out_prod_0(out_prod_0), .out_prod_1(out_prod_1),
    .out_prod_2(out_prod_2), .out_prod_3(out_prod_3)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit is_nan(logic [31:0] a);
    return (&a[30:23]) && (|a[22:0]);
  endfunction

  function automatic bit is_inf(logic [31:0] a);
    return (&a[30:23]) && !(|a[22:0]);
  endfunction

  // exact value of a finite float: mag * 2^e
  function automatic void split_f32(input logic [31:0] a, output logic [319:0] mag,
                                    output int e);
    mag = {296'd0, |a[30:23], a[22:0]};
    e = (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
  endfunction

  // round an exact value sign * mag * 2^e to nearest even binary32
  function automatic logic [31:0] round_f32(bit s, logic [319:0] mag, int e);
    int p, sh, ex, biased;
    logic [319:0] q;
    bit g, st;
    p = -1;
    for (int i = 319; i >= 0 && p < 0; i--) if (mag[i]) p = i;
    if (p < 0) return {s, 31'd0};
    sh = (p + e >= -126) ? p - 23 : -149 - e;
    if (sh <= 0) begin
      q = mag << (-sh);
    end else begin
      q = mag >> sh;
      g = mag[sh-1];
      st = |(mag & ((320'd1 << (sh - 1)) - 320'd1));
      if (g && (st || q[0])) q = q + 320'd1;
    end
    ex = e + sh;
    if (q[24]) begin
      q = q >> 1;
      ex++;
    end
    if (!q[23]) return {s, 8'd0, q[22:0]};
    biased = ex + 150;
    if (biased >= 255) return {s, 8'hFF, 23'd0};
    return {s, biased[7:0], q[22:0]};
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    logic [319:0] ma, mb;
    int ea, eb;
    bit s;
    s = a[31] ^ b[31];
    if (is_nan(a)) return a | FP_QBIT;
    if (is_nan(b)) return b | FP_QBIT;
    if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return FP_QNAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
    split_f32(a, ma, ea);
    split_f32(b, mb, eb);
    return round_f32(s, ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    logic [319:0] ma, mb, sum;
    int ea, eb, emin;
    bit s;
    if (is_nan(a)) return a | FP_QBIT;
    if (is_nan(b)) return b | FP_QBIT;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return FP_QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    split_f32(a, ma, ea);
    split_f32(b, mb, eb);
    emin = (ea < eb) ? ea : eb;
    ma = ma << (ea - emin);
    mb = mb << (eb - emin);
    if (a[31] == b[31]) begin
      sum = ma + mb;
      s = a[31];
    end else if (ma >= mb) begin
      sum = ma - mb;
      s = a[31];
    end else begin
      sum = mb - ma;
      s = b[31];
    end
    // exact cancellation gives +0, two negative zeros stay negative
    if (sum == 0) s = a[31] & b[31];
    return round_f32(s, sum, emin);
  endfunction

  // apply one accepted request to the right matrix copy or the product queue
  function automatic void take_request(row_req_t r);
    prod_row_t pr;
    logic [31:0] acc;
    if (r.op == OP_LOAD) begin
      for (int c = 0; c < 4; c++) right_rows[r.row][c] = r.el[c];
      n_loads++;
      return;
    end
    pr.row = r.row;
    for (int c = 0; c < 4; c++) begin
      acc = f32_mul(r.el[0], right_rows[0][c]);
      for (int k = 1; k < 4; k++) acc = f32_add(acc, f32_mul(r.el[k], right_rows[k][c]));
      pr.prod[c] = acc;
    end
    awaited.push_back(pr);
    n_mults++;
  endfunction

  function automatic logic [31:0] special_f32();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7F80_0000;
      3: return 32'hFF80_0000;
      4: return 32'h7FC0_0000;
      5: return {$urandom_range(0, 1) == 1, 8'hFF, 1'b0, 22'd1 | 22'($urandom)};
      6: return 32'h0000_0001;
      7: return 32'h7F7F_FFFF;
      8: return 32'h5555_5555;
      9: return 32'hAAAA_AAAA;
      10: return 32'hFFFF_FFFF;
      default: return 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_f32();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 19))
      0, 1: return special_f32();
      2: return {v[31], 8'd0, v[22:0]};
      3: return {v[31], 8'($urandom_range(1, 20)), v[22:0]};
      4: return {v[31], 8'($urandom_range(230, 254)), v[22:0]};
      5, 6: return v;
      default: return {v[31], 8'($urandom_range(110, 144)), v[22:0]};
    endcase
  endfunction

  function automatic row_req_t make_req(logic op, logic [1:0] row, bit specials);
    row_req_t r;
    r.op = op;
    r.row = row;
    r.drain = 1'b0;
    for (int c = 0; c < 4; c++) r.el[c] = specials ? special_f32() : rand_f32();
    return r;
  endfunction

  function automatic void put_row(logic op, logic [1:0] row, logic [31:0] a, logic [31:0] b,
                                  logic [31:0] c, logic [31:0] d);
    row_req_t r;
    r.op = op;
    r.row = row;
    r.el = {d, c, b, a};
    r.drain = 1'b0;
    pending.push_back(r);
  endfunction

  // request driver: bursts with random gaps, optional hold until the pipe drains
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) take_request(cur);
      if (!(in_valid && in_stall)) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0 && !(pending[0].drain && awaited.size() > 0)) begin
          cur = pending.pop_front();
          in_operation <= cur.op;
          in_row_index <= cur.row;
          in_elem_0 <= cur.el[0];
          in_elem_1 <= cur.el[1];
          in_elem_2 <= cur.el[2];
          in_elem_3 <= cur.el[3];
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    n_errors++;
    if (n_errors <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    prod_row_t pr;
    logic [3:0][31:0] got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_prod_3, out_prod_2, out_prod_1, out_prod_0};
        if (awaited.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch: product row %0d with none pending", out_row);
        end else begin
          pr = awaited.pop_front();
          n_checked++;
          if (out_row !== pr.row) note_mismatch("out_row", 32'(pr.row), 32'(out_row));
          for (int c = 0; c < 4; c++)
            if (got[c] !== pr.prod[c]) note_mismatch($sformatf("prod_%0d", c), pr.prod[c], got[c]);
        end
      end
      if (stall_run == 0) begin
        stall_run = $urandom_range(5, 60);
        stall_mode = $urandom_range(0, 2);
      end else begin
        stall_run--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    row_req_t r;
    // matrix of special values, then extreme left rows
    put_row(OP_LOAD, 2'd0, 32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000);
    put_row(OP_LOAD, 2'd1, 32'h3F80_0000, 32'h0000_0001, 32'h7F7F_FFFF, 32'h807F_FFFF);
    put_row(OP_LOAD, 2'd2, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0080_0000, 32'h4000_0000);
    put_row(OP_LOAD, 2'd3, 32'h3F80_0000, 32'hBF80_0000, 32'h7FC0_0001, 32'hFFFF_FFFF);
    put_row(OP_MUL, 2'd0, 32'h3F80_0000, 32'h0, 32'h0, 32'h0);
    put_row(OP_MUL, 2'd1, 32'h0, 32'h3F80_0000, 32'h0, 32'h0);
    put_row(OP_MUL, 2'd2, 32'h0, 32'h0, 32'h3F80_0000, 32'h0);
    put_row(OP_MUL, 2'd3, 32'h0, 32'h0, 32'h0, 32'h3F80_0000);
    put_row(OP_MUL, 2'd3, 32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA);
    put_row(OP_MUL, 2'd0, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0, 32'h0);
    // plain matrix for cancellation, overflow and underflow
    put_row(OP_LOAD, 2'd0, 32'h3F80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h8000_0000);
    put_row(OP_LOAD, 2'd1, 32'hBF80_0000, 32'h7F7F_FFFF, 32'h0080_0000, 32'h8000_0000);
    put_row(OP_LOAD, 2'd2, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0001, 32'h3F80_0000);
    put_row(OP_LOAD, 2'd3, 32'h3400_0000, 32'h3F80_0000, 32'h3F00_0000, 32'h8000_0000);
    put_row(OP_MUL, 2'd1, 32'h3F80_0000, 32'h3F80_0000, 32'h0, 32'h0);
    put_row(OP_MUL, 2'd2, 32'h4000_0000, 32'h4000_0000, 32'h0, 32'h0);
    put_row(OP_MUL, 2'd0, 32'h3F00_0000, 32'h3F00_0000, 32'h0, 32'h0);
    put_row(OP_MUL, 2'd3, 32'h3F80_0000, 32'h0, 32'h3F80_0000, 32'h3F80_0000);
    put_row(OP_MUL, 2'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    put_row(OP_MUL, 2'd2, 32'h7F80_0000, 32'hFF80_0000, 32'h0, 32'h0);
    for (int rw = 0; rw < 4; rw++) pending.push_back(make_req(OP_LOAD, 2'(rw), 1'b0));
    // random mix: mostly multiplies, with row reloads and occasional special rows
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 4) == 0)
        r = make_req(OP_LOAD, 2'($urandom_range(0, 3)), $urandom_range(0, 9) == 0);
      else
        r = make_req(OP_MUL, 2'($urandom_range(0, 3)), $urandom_range(0, 19) == 0);
      r.drain = (i == RANDOM_ITEMS / 2);
      pending.push_back(r);
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() > 0 || in_valid) @(posedge clk);
    while (awaited.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("row loads %0d, row multiplies %0d, product rows checked %0d",
             n_loads, n_mults, n_checked);
    $display("operands spanned zeros, denormals, infinities, nans and near-overflow values");
    if (n_errors == 0 && awaited.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("mismatch count %0d", n_errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
